>>> rtl/two_queue_alternating_dequeue_defines.svh
// Assertion macros for the two-queue alternating dequeue block.
// Used by the port-level checker; expects signals named clock and reset in scope.
`ifndef TWO_QUEUE_ALTERNATING_DEQUEUE_DEFINES_SVH
`define TWO_QUEUE_ALTERNATING_DEQUEUE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TQAD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TQAD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/tqad_pkg.sv
// Shared constants, codes and types for the two-queue alternating dequeue block.
// No dependencies; imported by every module of the block.
package tqad_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 32;

   // Request opcodes
   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   // Queue identifiers
   localparam logic Q_A = 1'b0;
   localparam logic Q_B = 1'b1;

   // Response status codes
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_DROPPED = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   // Occupancy flags of one queue
   typedef struct packed {
      logic empty;
      logic full;
   } queue_flags_type;

   // One response as it leaves the block
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              source;
      status_type        status;
   } result_type;

endpackage

>>> rtl/tqad_queue.sv
// One bounded FIFO: storage array, wrapping head/tail pointers and occupancy count.
// Depends on tqad_pkg; read data is registered and valid the cycle after a pop.
module tqad_queue
   import tqad_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output queue_flags_type   flags,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [QUEUE_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Advance a pointer, wrapping at the last entry
   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign flags.empty = (count_ff == '0);
   assign flags.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign rd_data     = rd_data_ff;

   // Next pointers and count; a push and a pop never hit the same queue together
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = wrap_next(tail_ff);
         count_in = count_ff + CNT_W'(1);
      end else if (pop) begin
         head_in  = wrap_next(head_ff);
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Storage: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[tail_ff] <= push_data;
      end
      if (pop) begin
         rd_data_ff <= store_ff[head_ff];
      end
   end

endmodule

>>> rtl/tqad_out_buf.sv
// Two-entry response buffer that decouples the result stall from the request side.
// Depends on tqad_pkg for the response type.
module tqad_out_buf
   import tqad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  result_type wr_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   result_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        rd_en;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign rd_en     = rsp_valid & ~rsp_stall;

   // Move pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Capture a response into the free slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/two_queue_alternating_dequeue.sv
// Two bounded FIFOs (A and B, QUEUE_DEPTH entries each) with an alternating dequeue turn.
// An enqueue request appends its value to the named queue or is dropped when that queue is
// full; a dequeue request pops from the queue whose turn it is, falls back to the other one
// when that is empty, and always flips the turn. Every request yields exactly one response.
// Throughput is one request per cycle while req_stall is low; a response shows on rsp_valid
// once it has passed the result stage, which holds the registered read of the queue storage,
// and been written into the response buffer. req_stall rises only while the two-entry
// response buffer is full and a finished response waits behind it.
// Depends on tqad_pkg, tqad_queue and tqad_out_buf.
module two_queue_alternating_dequeue
   import tqad_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic                     req_which_queue,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic                     rsp_out_source,
   output logic [1:0]               rsp_status
);

   queue_flags_type flags_a, flags_b;
   logic [DATA_W-1:0] rd_a, rd_b;
   logic       accept, is_enq, is_deq;
   logic       push_a, push_b, pop_a, pop_b;
   logic       target_full, first_empty, both_empty, pop_src;
   logic       turn_ff, turn_in;
   logic       a_valid_ff, a_valid_in;
   logic       a_pop_ff, a_pop_in;
   logic       a_src_ff, a_src_in;
   status_type a_status_ff, a_status_in;
   logic       a_adv, ob_full;
   result_type a_result, rsp_data;

   assign accept = req_valid & ~req_stall;
   assign is_enq = (req_op == OP_ENQ);
   assign is_deq = (req_op == OP_DEQ);

   // Decode the request against current occupancy
   always_comb begin
      target_full = (req_which_queue == Q_B) ? flags_b.full : flags_a.full;
      first_empty = (turn_ff == Q_B) ? flags_b.empty : flags_a.empty;
      both_empty  = flags_a.empty & flags_b.empty;
      pop_src     = first_empty ? ~turn_ff : turn_ff;

      push_a = accept & is_enq & (req_which_queue == Q_A) & ~target_full;
      push_b = accept & is_enq & (req_which_queue == Q_B) & ~target_full;
      pop_a  = accept & is_deq & ~both_empty & (pop_src == Q_A);
      pop_b  = accept & is_deq & ~both_empty & (pop_src == Q_B);

      turn_in = (accept & is_deq) ? ~turn_ff : turn_ff;

      a_pop_in = is_deq & ~both_empty;
      a_src_in = pop_src;
      if (is_enq) begin
         a_status_in = target_full ? ST_DROPPED : ST_DONE;
      end else begin
         a_status_in = both_empty ? ST_EMPTY : ST_DONE;
      end
   end

   tqad_queue u_queue_a (
      .clock     (clock),
      .reset     (reset),
      .push      (push_a),
      .push_data (req_value),
      .pop       (pop_a),
      .flags     (flags_a),
      .rd_data   (rd_a)
   );

   tqad_queue u_queue_b (
      .clock     (clock),
      .reset     (reset),
      .push      (push_b),
      .push_data (req_value),
      .pop       (pop_b),
      .flags     (flags_b),
      .rd_data   (rd_b)
   );

   // Advance the result stage when it is empty or the response buffer has room
   assign a_adv      = ~a_valid_ff | ~ob_full;
   assign req_stall  = a_valid_ff & ob_full;
   assign a_valid_in = a_adv ? accept : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff    <= Q_A;
         a_valid_ff <= 1'b0;
      end else begin
         turn_ff    <= turn_in;
         a_valid_ff <= a_valid_in;
      end
   end

   // Hold the decoded result alongside the queue read data
   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_pop_ff    <= a_pop_in;
         a_src_ff    <= a_src_in;
         a_status_ff <= a_status_in;
      end
   end

   // Form the response; non-pop results read as zero value and source A
   always_comb begin
      a_result.value  = '0;
      a_result.source = Q_A;
      a_result.status = a_status_ff;
      if (a_pop_ff) begin
         a_result.value  = (a_src_ff == Q_B) ? rd_b : rd_a;
         a_result.source = a_src_ff;
      end
   end

   tqad_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (a_valid_ff & a_adv),
      .wr_data   (a_result),
      .full      (ob_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_value  = rsp_data.value;
   assign rsp_out_source = rsp_data.source;
   assign rsp_status     = rsp_data.status;

endmodule

>>> rtl/tqad_check.sv
// Port-level checker for the two-queue alternating dequeue block, bound to the top level.
// Depends on tqad_pkg and the assertion macros in two_queue_alternating_dequeue_defines.svh.
`include "two_queue_alternating_dequeue_defines.svh"

module tqad_check
   import tqad_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_out_value,
   input logic                     rsp_out_source,
   input logic [1:0]               rsp_status
);

   logic              req_take;
   logic              rsp_failed;
   logic              rsp_blank;
   logic              rsp_waits;
   logic [DATA_W+2:0] rsp_payload;

   assign req_take    = req_valid && !req_stall;
   assign rsp_failed  = rsp_valid && (rsp_status != ST_DONE);
   assign rsp_blank   = (rsp_out_value == '0) && (rsp_out_source == Q_A);
   assign rsp_waits   = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_out_value, rsp_out_source, rsp_status};

   // Any response other than a good pop or enqueue carries zero payload
   `TQAD_ASSERT(a_fail_zero, rsp_failed |-> rsp_blank, "failed request carries a payload")

   // A stalled response holds
   `TQAD_ASSERT(a_rsp_hold, rsp_waits |=> rsp_valid && $stable(rsp_payload), "stalled response moved")

   // Reset empties the response side
   `TQAD_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_valid, "response pending after reset")

   // A response out of an empty buffer comes from a request taken through the result stage
   `TQAD_ASSERT(a_rsp_origin, $rose(rsp_valid) |-> $past(req_take, 2), "response without a request")

endmodule

bind two_queue_alternating_dequeue tqad_check u_tqad_check (.*);
